@@ hw/rtl/bmhq_pkg.sv @@
// Shared types and constants of the binary max-heap priority queue.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  localparam int unsigned CAPACITY    = 128;
  localparam int unsigned ADDR_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned CHILD_W     = ADDR_W + 2;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned COUNT_OUT_W = 8;

  localparam logic signed [KEY_W-1:0] EMPTY_KEY = 32'shFFFF_0000;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_PEEK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PARENT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_POP_LAST,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    start;
    rd_src_e rd_src;
    logic    cap_last;
    logic    cap_left;
    logic    up_step;
    logic    down_step;
    logic    place;
    logic    finish;
  } bmhq_cmd_t;

  typedef struct packed {
    op_e  req_op;
    logic full;
    logic empty;
    logic cnt_one;
    logic at_root;
    logic up_more;
    logic has_left;
    logic has_right;
    logic down_more;
  } bmhq_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/bmhq_if.sv @@
// Request and response channel interfaces of the heap queue.
// Depends on bmhq_pkg for the key and count widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmhq_req_if;
  import bmhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [KEY_W-1:0] key_in;

  modport source (output valid, output op, output key_in, input ready);
  modport sink (input valid, input op, input key_in, output ready);
endinterface

interface bmhq_rsp_if;
  import bmhq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [KEY_W-1:0] popped_key;
  logic signed [KEY_W-1:0] top_key;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   is_empty;
  logic                   is_full;
  logic                   push_dropped;
  logic                   pop_underflow;

  modport source (
    output valid, output popped_key, output top_key, output entry_count,
    output is_empty, output is_full, output push_dropped, output pop_underflow,
    input ready
  );
  modport sink (
    input valid, input popped_key, input top_key, input entry_count,
    input is_empty, input is_full, input push_dropped, input pop_underflow,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/bmhq_datapath.sv @@
// Datapath of the heap queue: key store, count, sift registers and result register.
// Depends on bmhq_pkg; driven by commands from bmhq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_datapath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire  [bmhq_pkg::OP_W-1:0]     op_i,
  input  wire  signed [bmhq_pkg::KEY_W-1:0] key_i,
  input  bmhq_pkg::bmhq_cmd_t           cmd_i,
  output bmhq_pkg::bmhq_sts_t           sts_o,
  output logic signed [bmhq_pkg::KEY_W-1:0] popped_key_o,
  output logic signed [bmhq_pkg::KEY_W-1:0] top_key_o,
  output logic [bmhq_pkg::COUNT_OUT_W-1:0]  entry_count_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic                          push_dropped_o,
  output logic                          pop_underflow_o
);
  import bmhq_pkg::*;

  logic signed [KEY_W-1:0] mem [CAPACITY];
  logic signed [KEY_W-1:0] rdata_q;
  logic signed [KEY_W-1:0] top_q;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [KEY_W-1:0] left_q;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [ADDR_W-1:0]       pos_q, pos_d;
  logic signed [KEY_W-1:0] popped_q, popped_d;
  logic                    dropped_q, dropped_d;
  logic                    underflow_q, underflow_d;

  op_e                     req_op;
  logic                    full, empty;
  logic [ADDR_W-1:0]       parent_idx;
  logic [CHILD_W-1:0]      left_idx, right_idx, cnt_ext;
  logic                    has_left, has_right;
  logic                    left_wins, right_wins, up_more, down_more;
  logic signed [KEY_W-1:0] best_val;
  logic [ADDR_W-1:0]       raddr;
  logic                    we;
  logic signed [KEY_W-1:0] wdata;

  assign req_op     = op_e'(op_i);
  assign full       = (cnt_q == CNT_W'(CAPACITY));
  assign empty      = (cnt_q == '0);
  assign parent_idx = ADDR_W'((pos_q - 1'b1) >> 1);
  assign left_idx   = CHILD_W'({pos_q, 1'b0}) + CHILD_W'(1);
  assign right_idx  = CHILD_W'({pos_q, 1'b0}) + CHILD_W'(2);
  assign cnt_ext    = CHILD_W'(cnt_q);
  assign has_left   = (left_idx < cnt_ext);
  assign has_right  = (right_idx < cnt_ext);
  assign up_more    = (rdata_q < key_q);
  assign left_wins  = (key_q < left_q);
  assign best_val   = left_wins ? left_q : key_q;
  assign right_wins = has_right && (best_val < rdata_q);
  assign down_more  = left_wins || right_wins;

  assign sts_o = '{
    req_op:    req_op,
    full:      full,
    empty:     empty,
    cnt_one:   (cnt_q == CNT_W'(1)),
    at_root:   (pos_q == '0),
    up_more:   up_more,
    has_left:  has_left,
    has_right: has_right,
    down_more: down_more
  };

  always_comb begin
    case (cmd_i.rd_src)
      RD_PARENT: raddr = parent_idx;
      RD_LAST:   raddr = ADDR_W'(cnt_q - 1'b1);
      RD_LEFT:   raddr = left_idx[ADDR_W-1:0];
      RD_RIGHT:  raddr = right_idx[ADDR_W-1:0];
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = key_q;
    if (cmd_i.place) begin
      we = 1'b1;
    end else if (cmd_i.up_step) begin
      we    = 1'b1;
      wdata = up_more ? rdata_q : key_q;
    end else if (cmd_i.down_step) begin
      we    = 1'b1;
      wdata = down_more ? (right_wins ? rdata_q : left_q) : key_q;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    key_d       = key_q;
    popped_d    = popped_q;
    dropped_d   = dropped_q;
    underflow_d = underflow_q;
    if (cmd_i.start) begin
      key_d       = key_i;
      popped_d    = EMPTY_KEY;
      dropped_d   = 1'b0;
      underflow_d = 1'b0;
      case (req_op)
        OP_PUSH: begin
          pos_d = ADDR_W'(cnt_q);
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        OP_POP: begin
          pos_d = '0;
          if (empty) begin
            underflow_d = 1'b1;
          end else begin
            cnt_d    = cnt_q - 1'b1;
            popped_d = top_q;
          end
        end
        OP_CLEAR: cnt_d = '0;
        default: cnt_d = cnt_q;
      endcase
    end
    if (cmd_i.cap_last) begin
      key_d = rdata_q;
    end
    if (cmd_i.up_step && up_more) begin
      pos_d = parent_idx;
    end
    if (cmd_i.down_step && down_more) begin
      pos_d = right_wins ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    key_q       <= key_d;
    popped_q    <= popped_d;
    dropped_q   <= dropped_d;
    underflow_q <= underflow_d;
    rdata_q     <= mem[raddr];
    if (cmd_i.cap_left) begin
      left_q <= rdata_q;
    end
    if (we) begin
      mem[pos_q] <= wdata;
      if (pos_q == '0) begin
        top_q <= wdata;
      end
    end
    if (cmd_i.finish) begin
      popped_key_o    <= popped_q;
      top_key_o       <= empty ? EMPTY_KEY : top_q;
      entry_count_o   <= COUNT_OUT_W'(cnt_q);
      is_empty_o      <= empty;
      is_full_o       <= full;
      push_dropped_o  <= dropped_q;
      pop_underflow_o <= underflow_q;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bmhq_ctrl.sv @@
// Controller of the heap queue: sequences sift-up and sift-down steps and the handshakes.
// Depends on bmhq_pkg; drives bmhq_datapath through a command struct.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  wire                 rsp_ready_i,
  input  bmhq_pkg::bmhq_sts_t sts_i,
  output bmhq_pkg::bmhq_cmd_t cmd_o
);
  import bmhq_pkg::*;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   out_free;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o = rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_src = RD_NONE;
    req_ready_o = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_DONE;
          if (sts_i.req_op == OP_PUSH && !sts_i.full) begin
            state_d = ST_PUSH_RD;
          end else if (sts_i.req_op == OP_POP && !sts_i.empty && !sts_i.cnt_one) begin
            cmd_o.rd_src = RD_LAST;
            state_d      = ST_POP_LAST;
          end
        end
      end
      ST_PUSH_RD: begin
        if (sts_i.at_root) begin
          cmd_o.place = 1'b1;
          state_d     = ST_DONE;
        end else begin
          cmd_o.rd_src = RD_PARENT;
          state_d      = ST_PUSH_CMP;
        end
      end
      ST_PUSH_CMP: begin
        cmd_o.up_step = 1'b1;
        state_d       = sts_i.up_more ? ST_PUSH_RD : ST_DONE;
      end
      ST_POP_LAST: begin
        cmd_o.cap_last = 1'b1;
        state_d        = ST_DN_RDL;
      end
      ST_DN_RDL: begin
        if (sts_i.has_left) begin
          cmd_o.rd_src = RD_LEFT;
          state_d      = ST_DN_RDR;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = ST_DONE;
        end
      end
      ST_DN_RDR: begin
        cmd_o.cap_left = 1'b1;
        if (sts_i.has_right) begin
          cmd_o.rd_src = RD_RIGHT;
        end
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmd_o.down_step = 1'b1;
        state_d         = sts_i.down_more ? ST_DN_RDL : ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          rsp_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/binary_max_heap_queue.sv @@
// Binary max-heap priority queue with a request and a response channel.
// Usage:
//   Each request transaction on req_i carries op (push, pop, clear, peek) and
//   key_in, a signed Q16.16 key used only by push. Every request yields exactly
//   one response transaction on rsp_o with the popped key, the new top key, the
//   entry count and the empty, full, dropped and underflow flags.
//   Keys live in a store of 128 entries with a registered read, so
//   each level of a sift costs one read (two on a pop), a compare and a write.
//   A push sifts its key up level by level until a compare stops it or it
//   reaches the root; a pop moves the last entry to the root and sifts it down
//   until it reaches a leaf or a compare stops it. Clear, peek, a dropped push,
//   an underflowing pop and a pop of the only entry do no sift.
//   One request is processed at a time; a new request is taken while the
//   previous response still waits in the output register.
//   If the receiver stalls, the response is held and the queue waits at the
//   end of the next request until the output register frees.
//   Reset empties the heap at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue (
  input  wire        clk_i,
  input  wire        rst_ni,
  bmhq_req_if.sink   req_i,
  bmhq_rsp_if.source rsp_o
);
  import bmhq_pkg::*;

  bmhq_cmd_t cmd;
  bmhq_sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bmhq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (req_i.op),
    .key_i           (req_i.key_in),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .popped_key_o    (rsp_o.popped_key),
    .top_key_o       (rsp_o.top_key),
    .entry_count_o   (rsp_o.entry_count),
    .is_empty_o      (rsp_o.is_empty),
    .is_full_o       (rsp_o.is_full),
    .push_dropped_o  (rsp_o.push_dropped),
    .pop_underflow_o (rsp_o.pop_underflow)
  );

endmodule

`default_nettype wire
